// File: rtl/sgi_pkg.sv
// Shared constants and width helpers for the segment intersection block.
`default_nettype none
package sgi_pkg;

  localparam int BWidth          = 16;
  localparam int CoordWidthDef   = 24;
  localparam int FracBitsDef     = 8;
  localparam int QueueDepth      = 4;

  // width of the common coordinate format for A and scaled B
  function automatic int wide_w(int cw, int fb);
    return (cw > BWidth + fb) ? cw : BWidth + fb;
  endfunction

  function automatic int dlt_w(int cw, int fb);
    return wide_w(cw, fb) + 1;
  endfunction

  function automatic int ext_w(int cw, int fb);
    return 2 * dlt_w(cw, fb) + 1;
  endfunction

  // hit, tn, den, dax, day, ax1, ay1
  function automatic int item_w(int cw, int fb);
    return 1 + 2 * ext_w(cw, fb) + 2 * dlt_w(cw, fb) + 2 * cw;
  endfunction

endpackage
`default_nettype wire

// File: rtl/sgi_fifo.sv
// Small first-in first-out queue.
`default_nettype none
module sgi_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);
  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem [Depth];
  logic [PtrW-1:0]  wr_q, rd_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end
endmodule
`default_nettype wire

// File: rtl/sgi_front.sv
// Front pipeline: deltas, cross products and the hit classification.
`default_nettype none
module sgi_front #(
  parameter int CoordWidth = sgi_pkg::CoordWidthDef,
  parameter int FracBits   = sgi_pkg::FracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic signed [CoordWidth-1:0]  a_start_x_i,
  input  logic signed [CoordWidth-1:0]  a_start_y_i,
  input  logic signed [CoordWidth-1:0]  a_end_x_i,
  input  logic signed [CoordWidth-1:0]  a_end_y_i,
  input  logic signed [sgi_pkg::BWidth-1:0] b_start_x_i,
  input  logic signed [sgi_pkg::BWidth-1:0] b_start_y_i,
  input  logic signed [sgi_pkg::BWidth-1:0] b_end_x_i,
  input  logic signed [sgi_pkg::BWidth-1:0] b_end_y_i,
  input  logic                          mid_full_i,
  output logic                          mid_push_o,
  output logic [sgi_pkg::item_w(CoordWidth, FracBits)-1:0] item_o
);
  import sgi_pkg::*;

  localparam int WW = wide_w(CoordWidth, FracBits);
  localparam int DW = dlt_w(CoordWidth, FracBits);
  localparam int PW = 2 * DW;
  localparam int ES = ext_w(CoordWidth, FracBits);

  logic adv;
  logic v1_q, v2_q, v3_q;

  logic signed [WW-1:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
  logic signed [DW-1:0] dax_d, day_d, dbx_d, dby_d, ox_d, oy_d;

  // stage 1
  logic signed [DW-1:0] dax1_q, day1_q, dbx1_q, dby1_q, ox1_q, oy1_q;
  logic signed [CoordWidth-1:0] ax1_q, ay1_q;
  // stage 2
  logic signed [PW-1:0] pd1_q, pd2_q, pt1_q, pt2_q, ps1_q, ps2_q;
  logic signed [DW-1:0] dax2_q, day2_q;
  logic signed [CoordWidth-1:0] ax2_q, ay2_q;
  // stage 3
  logic signed [ES-1:0] den, tn, sn, dm_d, tm_d, sm_d;
  logic                 hit_d, hit3_q;
  logic [ES-1:0]        tm3_q, dm3_q;
  logic signed [DW-1:0] dax3_q, day3_q;
  logic signed [CoordWidth-1:0] ax3_q, ay3_q;

  assign adv = !mid_full_i;

  assign ax1 = WW'(a_start_x_i);
  assign ay1 = WW'(a_start_y_i);
  assign ax2 = WW'(a_end_x_i);
  assign ay2 = WW'(a_end_y_i);
  assign bx1 = WW'(b_start_x_i) <<< FracBits;
  assign by1 = WW'(b_start_y_i) <<< FracBits;
  assign bx2 = WW'(b_end_x_i) <<< FracBits;
  assign by2 = WW'(b_end_y_i) <<< FracBits;

  assign dax_d = DW'(ax2) - DW'(ax1);
  assign day_d = DW'(ay2) - DW'(ay1);
  assign dbx_d = DW'(bx2) - DW'(bx1);
  assign dby_d = DW'(by2) - DW'(by1);
  assign ox_d  = DW'(ax1) - DW'(bx1);
  assign oy_d  = DW'(ay1) - DW'(by1);

  assign den = ES'(pd1_q) - ES'(pd2_q);
  assign tn  = ES'(pt1_q) - ES'(pt2_q);
  assign sn  = ES'(ps1_q) - ES'(ps2_q);

  // fold the sign of den into both numerators
  assign dm_d = den[ES-1] ? -den : den;
  assign tm_d = den[ES-1] ? -tn  : tn;
  assign sm_d = den[ES-1] ? -sn  : sn;

  assign hit_d = (den != '0) && !tm_d[ES-1] && !sm_d[ES-1]
              && ($unsigned(tm_d) <= $unsigned(dm_d))
              && ($unsigned(sm_d) <= $unsigned(dm_d))
              && !((tm_d == '0) && (sm_d == '0));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dax1_q <= dax_d;
      day1_q <= day_d;
      dbx1_q <= dbx_d;
      dby1_q <= dby_d;
      ox1_q  <= ox_d;
      oy1_q  <= oy_d;
      ax1_q  <= a_start_x_i;
      ay1_q  <= a_start_y_i;

      pd1_q  <= dby1_q * dax1_q;
      pd2_q  <= dbx1_q * day1_q;
      pt1_q  <= dbx1_q * oy1_q;
      pt2_q  <= dby1_q * ox1_q;
      ps1_q  <= dax1_q * oy1_q;
      ps2_q  <= day1_q * ox1_q;
      dax2_q <= dax1_q;
      day2_q <= day1_q;
      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;

      hit3_q <= hit_d;
      tm3_q  <= tm_d;
      dm3_q  <= dm_d;
      dax3_q <= dax2_q;
      day3_q <= day2_q;
      ax3_q  <= ax2_q;
      ay3_q  <= ay2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv) begin
      v1_q <= push_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign mid_push_o = adv && v3_q;
  assign item_o = {hit3_q, tm3_q, dm3_q, dax3_q, day3_q, ax3_q, ay3_q};
endmodule
`default_nettype wire

// File: rtl/sgi_back.sv
// Back pipeline: scaled numerators and a pipelined restoring divider per axis.
`default_nettype none
module sgi_back #(
  parameter int CoordWidth = sgi_pkg::CoordWidthDef,
  parameter int FracBits   = sgi_pkg::FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic mid_empty_i,
  input  logic [sgi_pkg::item_w(CoordWidth, FracBits)-1:0] item_i,
  output logic mid_pop_o,
  input  logic out_full_i,
  output logic out_push_o,
  output logic [2*CoordWidth:0] result_o
);
  import sgi_pkg::*;

  localparam int DW = dlt_w(CoordWidth, FracBits);
  localparam int ES = ext_w(CoordWidth, FracBits);
  localparam int QB = DW;
  localparam int NW = ES + DW;
  localparam int HL = ES / 2;
  localparam int HH = ES - HL;

  logic adv;

  logic                 in_hit;
  logic [ES-1:0]        in_tm, in_dm;
  logic signed [DW-1:0] in_dax, in_day;
  logic [CoordWidth-1:0] in_ax, in_ay;
  logic [DW-1:0]        mdx, mdy;

  // multiply stage
  logic                 vm_q, hm_q, sxm_q, sym_q;
  logic [HL+DW-1:0]     lox_q, loy_q;
  logic [HH+DW-1:0]     hix_q, hiy_q;
  logic [ES-1:0]        dmm_q;
  logic [CoordWidth-1:0] axm_q, aym_q;
  logic [NW-1:0]        nx, ny;

  // divider stages
  logic                 vd_q  [QB+1];
  logic                 hd_q  [QB+1];
  logic                 sxd_q [QB+1];
  logic                 syd_q [QB+1];
  logic [ES-1:0]        dd_q  [QB+1];
  logic [ES-1:0]        rx_q  [QB+1];
  logic [ES-1:0]        ry_q  [QB+1];
  logic [QB-1:0]        lx_q  [QB+1];
  logic [QB-1:0]        ly_q  [QB+1];
  logic [QB-1:0]        qx_q  [QB+1];
  logic [QB-1:0]        qy_q  [QB+1];
  logic [CoordWidth-1:0] axd_q [QB+1];
  logic [CoordWidth-1:0] ayd_q [QB+1];

  logic [CoordWidth-1:0] cx, cy;

  assign adv       = !out_full_i;
  assign mid_pop_o = adv && !mid_empty_i;

  assign {in_hit, in_tm, in_dm, in_dax, in_day, in_ax, in_ay} = item_i;
  assign mdx = in_dax[DW-1] ? DW'(-in_dax) : DW'(in_dax);
  assign mdy = in_day[DW-1] ? DW'(-in_day) : DW'(in_day);

  assign nx = NW'(lox_q) + (NW'(hix_q) << HL);
  assign ny = NW'(loy_q) + (NW'(hiy_q) << HL);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hm_q  <= in_hit;
      sxm_q <= in_dax[DW-1];
      sym_q <= in_day[DW-1];
      lox_q <= in_tm[HL-1:0] * mdx;
      loy_q <= in_tm[HL-1:0] * mdy;
      hix_q <= in_tm[ES-1:HL] * mdx;
      hiy_q <= in_tm[ES-1:HL] * mdy;
      dmm_q <= in_dm;
      axm_q <= in_ax;
      aym_q <= in_ay;

      hd_q[0]  <= hm_q;
      sxd_q[0] <= sxm_q;
      syd_q[0] <= sym_q;
      dd_q[0]  <= dmm_q;
      rx_q[0]  <= nx[NW-1:QB];
      ry_q[0]  <= ny[NW-1:QB];
      lx_q[0]  <= nx[QB-1:0];
      ly_q[0]  <= ny[QB-1:0];
      qx_q[0]  <= '0;
      qy_q[0]  <= '0;
      axd_q[0] <= axm_q;
      ayd_q[0] <= aym_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q    <= 1'b0;
      vd_q[0] <= 1'b0;
    end else if (adv) begin
      vm_q    <= mid_pop_o;
      vd_q[0] <= vm_q;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [ES:0]   tx, ty;
    logic          gx, gy;

    // shift in one numerator bit, subtract the divisor when it fits
    assign tx = {rx_q[k], lx_q[k][QB-1]};
    assign ty = {ry_q[k], ly_q[k][QB-1]};
    assign gx = (tx >= {1'b0, dd_q[k]});
    assign gy = (ty >= {1'b0, dd_q[k]});

    always_ff @(posedge clk_i) begin
      if (adv) begin
        hd_q[k+1]  <= hd_q[k];
        sxd_q[k+1] <= sxd_q[k];
        syd_q[k+1] <= syd_q[k];
        dd_q[k+1]  <= dd_q[k];
        rx_q[k+1]  <= gx ? ES'(tx - {1'b0, dd_q[k]}) : ES'(tx);
        ry_q[k+1]  <= gy ? ES'(ty - {1'b0, dd_q[k]}) : ES'(ty);
        lx_q[k+1]  <= lx_q[k] << 1;
        ly_q[k+1]  <= ly_q[k] << 1;
        qx_q[k+1]  <= {qx_q[k][QB-2:0], gx};
        qy_q[k+1]  <= {qy_q[k][QB-2:0], gy};
        axd_q[k+1] <= axd_q[k];
        ayd_q[k+1] <= ayd_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[k+1] <= 1'b0;
      end else if (adv) begin
        vd_q[k+1] <= vd_q[k];
      end
    end
  end

  assign cx = sxd_q[QB] ? axd_q[QB] - CoordWidth'(qx_q[QB])
                        : axd_q[QB] + CoordWidth'(qx_q[QB]);
  assign cy = syd_q[QB] ? ayd_q[QB] - CoordWidth'(qy_q[QB])
                        : ayd_q[QB] + CoordWidth'(qy_q[QB]);

  assign out_push_o = adv && vd_q[QB];
  assign result_o   = hd_q[QB] ? {1'b1, cx, cy} : '0;
endmodule
`default_nettype wire

// File: rtl/segment_intersection.sv
// Segment intersection top level: front pipeline, middle queue, back pipeline, result queue.
//
// Usage: write one segment pair per beat on the input queue port (push while
// full is low). Segment A is signed fixed point with FRAC_BITS fraction bits,
// segment B is in signed 16-bit integers. Each pair gives exactly one result
// beat: hit_o, cross_x_o and cross_y_o, read from the output queue port while
// empty is low and taken with pop. A miss returns hit low and zero coordinates.
// Throughput: one pair per cycle while full is low. The divider resolves one
// quotient bit per stage. Reset empties both queues and all pipeline valid
// bits; nothing else is held. When the receiver stops popping, the result
// queue fills, the back pipeline freezes, the middle queue fills behind it
// and full rises; no beat is lost.
`default_nettype none
module segment_intersection #(
  parameter int COORD_WIDTH = sgi_pkg::CoordWidthDef,
  parameter int FRAC_BITS   = sgi_pkg::FracBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  logic signed [COORD_WIDTH-1:0] a_start_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_start_y_i,
  input  logic signed [COORD_WIDTH-1:0] a_end_x_i,
  input  logic signed [COORD_WIDTH-1:0] a_end_y_i,
  input  logic signed [sgi_pkg::BWidth-1:0] b_start_x_i,
  input  logic signed [sgi_pkg::BWidth-1:0] b_start_y_i,
  input  logic signed [sgi_pkg::BWidth-1:0] b_end_x_i,
  input  logic signed [sgi_pkg::BWidth-1:0] b_end_y_i,
  output logic empty,
  input  logic pop,
  output logic hit_o,
  output logic signed [COORD_WIDTH-1:0] cross_x_o,
  output logic signed [COORD_WIDTH-1:0] cross_y_o
);
  import sgi_pkg::*;

  localparam int ItemW = item_w(COORD_WIDTH, FRAC_BITS);
  localparam int ResW  = 2 * COORD_WIDTH + 1;

  logic             mid_push, mid_full, mid_pop, mid_empty;
  logic [ItemW-1:0] mid_in, mid_out;
  logic             out_push, out_full;
  logic [ResW-1:0]  res_in, res_out;

  assign full = mid_full;

  sgi_front #(
    .CoordWidth(COORD_WIDTH),
    .FracBits  (FRAC_BITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .push_i     (push && !full),
    .a_start_x_i,
    .a_start_y_i,
    .a_end_x_i,
    .a_end_y_i,
    .b_start_x_i,
    .b_start_y_i,
    .b_end_x_i,
    .b_end_y_i,
    .mid_full_i (mid_full),
    .mid_push_o (mid_push),
    .item_o     (mid_in)
  );

  sgi_fifo #(
    .Width(ItemW),
    .Depth(QueueDepth)
  ) u_mid (
    .clk_i,
    .rst_ni,
    .push_i (mid_push),
    .data_i (mid_in),
    .full_o (mid_full),
    .pop_i  (mid_pop),
    .data_o (mid_out),
    .empty_o(mid_empty)
  );

  sgi_back #(
    .CoordWidth(COORD_WIDTH),
    .FracBits  (FRAC_BITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .mid_empty_i(mid_empty),
    .item_i     (mid_out),
    .mid_pop_o  (mid_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .result_o   (res_in)
  );

  sgi_fifo #(
    .Width(ResW),
    .Depth(QueueDepth)
  ) u_out (
    .clk_i,
    .rst_ni,
    .push_i (out_push),
    .data_i (res_in),
    .full_o (out_full),
    .pop_i  (pop),
    .data_o (res_out),
    .empty_o(empty)
  );

  assign {hit_o, cross_x_o, cross_y_o} = res_out;
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// Self-checking testbench for the segment intersection block.
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW       = sgi_pkg::CoordWidthDef;
  localparam int FB       = sgi_pkg::FracBitsDef;
  localparam int BW       = sgi_pkg::BWidth;
  localparam int LATENCY  = CW + 7 + 20;
  localparam int MaxCycle = 2000000;

  typedef struct packed {
    logic signed [CW-1:0] a_start_x;
    logic signed [CW-1:0] a_start_y;
    logic signed [CW-1:0] a_end_x;
    logic signed [CW-1:0] a_end_y;
    logic signed [BW-1:0] b_start_x;
    logic signed [BW-1:0] b_start_y;
    logic signed [BW-1:0] b_end_x;
    logic signed [BW-1:0] b_end_y;
  } seg_pair_t;

  typedef struct packed {
    logic                 hit;
    logic signed [CW-1:0] cross_x;
    logic signed [CW-1:0] cross_y;
  } crossing_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic pop = 1'b0;
  logic full, empty, hit_o;
  logic signed [CW-1:0] cross_x_o, cross_y_o;
  seg_pair_t pair_d = '0;

  crossing_t pending_crossings[$];
  int unsigned mismatches = 0;
  int unsigned cycle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold_cycles = 0;

  segment_intersection u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .a_start_x_i (pair_d.a_start_x),
    .a_start_y_i (pair_d.a_start_y),
    .a_end_x_i   (pair_d.a_end_x),
    .a_end_y_i   (pair_d.a_end_y),
    .b_start_x_i (pair_d.b_start_x),
    .b_start_y_i (pair_d.b_start_y),
    .b_end_x_i   (pair_d.b_end_x),
    .b_end_y_i   (pair_d.b_end_y),
    .empty       (empty),
    .pop         (pop),
    .hit_o       (hit_o),
    .cross_x_o   (cross_x_o),
    .cross_y_o   (cross_y_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // exact parametric test in wide two's complement, no rounding until the divide
  function automatic crossing_t predict_crossing(seg_pair_t p);
    logic signed [127:0] ax1, ay1, ax2, ay2, bx1, by1, bx2, by2;
    logic signed [127:0] dax, day, dbx, dby, ox, oy, den, tn, sn, px, py;
    crossing_t r;
    r = '0;
    ax1 = 128'(p.a_start_x);
    ay1 = 128'(p.a_start_y);
    ax2 = 128'(p.a_end_x);
    ay2 = 128'(p.a_end_y);
    bx1 = 128'(p.b_start_x);
    by1 = 128'(p.b_start_y);
    bx2 = 128'(p.b_end_x);
    by2 = 128'(p.b_end_y);
    bx1 = bx1 <<< FB;
    by1 = by1 <<< FB;
    bx2 = bx2 <<< FB;
    by2 = by2 <<< FB;
    dax = ax2 - ax1;
    day = ay2 - ay1;
    dbx = bx2 - bx1;
    dby = by2 - by1;
    ox = ax1 - bx1;
    oy = ay1 - by1;
    den = dby * dax - dbx * day;
    tn = dbx * oy - dby * ox;
    sn = dax * oy - day * ox;
    if (den == 0) return r;
    if (den < 0) begin
      den = -den;
      tn = -tn;
      sn = -sn;
    end
    if (tn < 0 || tn > den || sn < 0 || sn > den || (tn == 0 && sn == 0)) return r;
    px = ax1 + (tn * dax) / den;
    py = ay1 + (tn * day) / den;
    r.hit = 1'b1;
    r.cross_x = px[CW-1:0];
    r.cross_y = py[CW-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycle) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // predict on each accepted input beat, check each accepted result beat
  always @(posedge clk_i) begin
    crossing_t want;
    if (rst_ni && push && !full) pending_crossings.push_back(predict_crossing(pair_d));
    if (rst_ni && pop && !empty) begin
      if (pending_crossings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat hit=%0b", hit_o);
      end else begin
        want = pending_crossings.pop_front();
        if (hit_o !== want.hit || cross_x_o !== want.cross_x
            || cross_y_o !== want.cross_y) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0b x=%0d y=%0d, got hit=%0b x=%0d y=%0d",
                     want.hit, want.cross_x, want.cross_y, hit_o, cross_x_o, cross_y_o);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (recv_hold_cycles > 0) begin
      recv_hold_cycles <= recv_hold_cycles - 1;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_pair(seg_pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    pair_d <= p;
    do @(posedge clk_i); while (full);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_crossings.size() != 0) @(posedge clk_i);
  endtask

  function automatic int signed pick_signed(int unsigned r);
    return int'($urandom_range(2 * r)) - int'(r);
  endfunction

  function automatic seg_pair_t make_pair(int ax1, int ay1, int ax2, int ay2,
                                          int bx1, int by1, int bx2, int by2);
    seg_pair_t p;
    p.a_start_x = CW'(ax1);
    p.a_start_y = CW'(ay1);
    p.a_end_x = CW'(ax2);
    p.a_end_y = CW'(ay2);
    p.b_start_x = BW'(bx1);
    p.b_start_y = BW'(by1);
    p.b_end_x = BW'(bx2);
    p.b_end_y = BW'(by2);
    return p;
  endfunction

  function automatic seg_pair_t random_pair();
    seg_pair_t p;
    int unsigned kind, r;
    int k;
    kind = $urandom_range(99);
    r = (kind % 4 == 0) ? 4 : (kind % 4 == 1) ? 60 : (kind % 4 == 2) ? 1000 : 32767;
    p.b_start_x = BW'(pick_signed(r));
    p.b_start_y = BW'(pick_signed(r));
    p.b_end_x = BW'(pick_signed(r));
    p.b_end_y = BW'(pick_signed(r));
    p.a_start_x = CW'(pick_signed(r) * 256 + int'($urandom_range(255)) - 128);
    p.a_start_y = CW'(pick_signed(r) * 256 + int'($urandom_range(255)) - 128);
    p.a_end_x = CW'(pick_signed(r) * 256 + int'($urandom_range(255)) - 128);
    p.a_end_y = CW'(pick_signed(r) * 256 + int'($urandom_range(255)) - 128);
    if (kind < 12) begin
      // raw full-range noise
      p = {$urandom(), $urandom(), $urandom(), $urandom(), $urandom()};
    end else if (kind < 22) begin
      // parallel or collinear: A runs along a multiple of B's direction
      k = pick_signed(3);
      if (kind < 16) begin
        p.a_start_x = CW'(p.b_start_x * 256);
        p.a_start_y = CW'(p.b_start_y * 256);
      end
      p.a_end_x = CW'(p.a_start_x + k * 64 * (p.b_end_x - p.b_start_x));
      p.a_end_y = CW'(p.a_start_y + k * 64 * (p.b_end_y - p.b_start_y));
    end else if (kind < 27) begin
      // A starts on B's start
      p.a_start_x = CW'(p.b_start_x * 256);
      p.a_start_y = CW'(p.b_start_y * 256);
    end
    return p;
  endfunction

  task automatic test_directed();
    localparam int AMax = (1 << (CW - 1)) - 1;
    localparam int AMin = -(1 << (CW - 1));
    localparam int BMax = 32767;
    localparam int BMin = -32768;
    // plain X crossing
    send_pair(make_pair(-2560, -2560, 2560, 2560, -10, 10, 10, -10));
    // touch at A's end and at B's end
    send_pair(make_pair(0, 0, 2560, 0, 10, -5, 10, 5));
    send_pair(make_pair(-1280, 1280, 1280, 1280, -5, -5, 0, 5));
    // parallel, collinear overlap, both numerators zero
    send_pair(make_pair(0, 0, 2560, 0, 0, 1, 10, 1));
    send_pair(make_pair(0, 0, 2560, 0, 5, 0, 20, 0));
    send_pair(make_pair(256, 512, 2560, -256, 1, 2, 7, 9));
    // t beyond 1, s below 0
    send_pair(make_pair(0, 0, 1280, 0, 10, -5, 10, 5));
    send_pair(make_pair(0, 0, 2560, 0, 5, 1, 5, 9));
    // degenerate segments
    send_pair(make_pair(256, 256, 256, 256, 0, 0, 2, 2));
    send_pair(make_pair(0, 0, 2560, 2560, 3, 3, 3, 3));
    // field extremes
    send_pair(make_pair(AMin, AMin, AMax, AMax, BMin, BMax, BMax, BMin));
    send_pair(make_pair(AMax, AMin, AMin, AMax, BMin, BMin, BMax, BMax));
    send_pair(make_pair(AMin, 0, AMax, 0, 0, BMin, 0, BMax));
    send_pair(make_pair(0, AMax, 0, AMin, BMax, 0, BMin, 0));
    send_pair(make_pair(AMax, AMax, AMax, AMax, BMax, BMax, BMax, BMax));
    send_pair(make_pair(AMin, AMin, AMin, AMin, BMin, BMin, BMin, BMin));
    send_pair(make_pair(-1, -1, 1, 1, -1, 1, 1, -1));
    // fractional crossing with negative truncation
    send_pair(make_pair(-333, -77, 901, 55, -3, 2, 4, -1));
    send_pair(make_pair(77, -1000, -45, 999, 3, -1, -2, 1));
    wait_drained();
  endtask

  task automatic test_random(int n, int unsigned s_idle, int unsigned r_idle);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    repeat (n) send_pair(random_pair());
    stop_sending();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_hold_cycles <= 200;
    repeat (40) send_pair(random_pair());
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_random(180, 13, 52);
    test_random(180, 52, 13);
    test_backpressure();
    test_random(160, 0, 0);
    wait_drained();
    repeat (LATENCY) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
